FILE: hw/rtl/crc8fr_pkg.sv
// Shared types and constants of the framed CRC-8 receiver.
package crc8fr_pkg;

  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned CFG_INDEX_W = 8;
  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [BYTE_W-1:0] BYTE_CR    = 8'h0D;
  localparam logic [BYTE_W-1:0] BYTE_LF    = 8'h0A;
  localparam logic [BYTE_W-1:0] BYTE_OPEN  = 8'h3C;
  localparam logic [BYTE_W-1:0] BYTE_CLOSE = 8'h3E;
  localparam logic [BYTE_W-1:0] BYTE_COMMA = 8'h2C;
  localparam logic [BYTE_W-1:0] BYTE_DIG0  = 8'h30;
  localparam logic [BYTE_W-1:0] BYTE_DIG9  = 8'h39;

  localparam logic [CFG_INDEX_W-1:0] CFG_MAX_LEN = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_POLY    = 8'd1;

  localparam logic [BYTE_W-1:0] MAX_LEN_RESET = 8'd255;
  localparam logic [BYTE_W-1:0] POLY_RESET    = 8'h07;

  typedef enum logic [2:0] {
    K_SKIP,
    K_OPEN,
    K_CLOSE,
    K_COMMA,
    K_DIGIT,
    K_OTHER
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [BYTE_W-1:0] data;
  } item_t;

  typedef enum logic [1:0] {
    ST_GOOD     = 2'd0,
    ST_NO_COMMA = 2'd1,
    ST_MISMATCH = 2'd2
  } status_t;

  typedef struct packed {
    logic              in_frame;
    logic [BYTE_W-1:0] count;
    logic [BYTE_W-1:0] crc;
    logic [BYTE_W-1:0] crc_at_comma;
    logic              comma_seen;
    logic [BYTE_W-1:0] comma_pos;
    logic [BYTE_W-1:0] dec;
    logic              dec_stopped;
    logic [BYTE_W-1:0] first_byte;
  } frame_t;

endpackage

FILE: hw/rtl/crc8_checked_ascii_frame_receiver_unit.sv
// Top level of the framed CRC-8 checked serial receiver.
//
//  channel | direction | handshake         | payload
//  --------+-----------+-------------------+-------------------------------------
//  in      | input     | in_valid/in_stall | rx_byte
//  out     | output    | out_valid/out_stall | frame_status, command_byte,
//          |           |                   | data_length, computed_crc, received_crc
//  cfg     | input     | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// One byte per cycle sustained while neither in_stall nor out_stall holds it; the
// back end's combinational CRC-8 and decimal update per popped item set that rate.
// With the queue empty, the closing byte passes through the queue, then the result register.
// Reset is synchronous; no clearing pass, the block accepts bytes right away.
// in_stall rises when the QUEUE_DEPTH-entry queue is full; while out_valid is high, out_stall
// holds the result register and the back end stops popping.
module crc8_checked_ascii_frame_receiver_unit #(
  parameter int unsigned QUEUE_DEPTH = crc8fr_pkg::QUEUE_DEPTH
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [crc8fr_pkg::BYTE_W-1:0]       rx_byte,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [1:0]                          frame_status,
  output logic [crc8fr_pkg::BYTE_W-1:0]       command_byte,
  output logic [crc8fr_pkg::BYTE_W-1:0]       data_length,
  output logic [crc8fr_pkg::BYTE_W-1:0]       computed_crc,
  output logic [crc8fr_pkg::BYTE_W-1:0]       received_crc,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [crc8fr_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [crc8fr_pkg::BYTE_W-1:0]       cfg_data
);

  logic              q_full;
  logic              push;
  crc8fr_pkg::item_t push_item;
  logic              pop;
  logic              q_valid;
  crc8fr_pkg::item_t q_item;

  assign cfg_ready = 1'b1;

  crc8fr_front u_front (
    .in_valid  (in_valid),
    .rx_byte   (rx_byte),
    .in_stall  (in_stall),
    .q_full    (q_full),
    .push      (push),
    .push_item (push_item)
  );

  crc8fr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (q_full),
    .pop       (pop),
    .q_valid   (q_valid),
    .q_item    (q_item)
  );

  crc8fr_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .q_valid      (q_valid),
    .q_item       (q_item),
    .q_pop        (pop),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .frame_status (frame_status),
    .command_byte (command_byte),
    .data_length  (data_length),
    .computed_crc (computed_crc),
    .received_crc (received_crc)
  );

endmodule

FILE: hw/rtl/crc8fr_front.sv
// Front end: classifies received bytes and pushes all but CR and LF into the queue.
module crc8fr_front (
  input  logic                                in_valid,
  input  logic [crc8fr_pkg::BYTE_W-1:0]       rx_byte,
  output logic                                in_stall,
  input  logic                                q_full,
  output logic                                push,
  output crc8fr_pkg::item_t                   push_item
);

  crc8fr_pkg::kind_t kind;

  always_comb begin
    unique case (rx_byte) inside
      crc8fr_pkg::BYTE_CR, crc8fr_pkg::BYTE_LF: kind = crc8fr_pkg::K_SKIP;
      crc8fr_pkg::BYTE_OPEN:                    kind = crc8fr_pkg::K_OPEN;
      crc8fr_pkg::BYTE_CLOSE:                   kind = crc8fr_pkg::K_CLOSE;
      crc8fr_pkg::BYTE_COMMA:                   kind = crc8fr_pkg::K_COMMA;
      [crc8fr_pkg::BYTE_DIG0:crc8fr_pkg::BYTE_DIG9]: kind = crc8fr_pkg::K_DIGIT;
      default:                                  kind = crc8fr_pkg::K_OTHER;
    endcase
  end

  assign in_stall       = q_full;
  assign push           = in_valid && !q_full && (kind != crc8fr_pkg::K_SKIP);
  assign push_item.kind = kind;
  assign push_item.data = rx_byte;

endmodule

FILE: hw/rtl/crc8fr_queue.sv
// Short queue of classified items between front and back ends.
module crc8fr_queue #(
  parameter int unsigned DEPTH = crc8fr_pkg::QUEUE_DEPTH
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  crc8fr_pkg::item_t push_item,
  output logic              full,
  input  logic              pop,
  output logic              q_valid,
  output crc8fr_pkg::item_t q_item
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  crc8fr_pkg::item_t mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full    = (count == FULL_CNT);
  assign q_valid = (count != '0);
  assign q_item  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

FILE: hw/rtl/crc8fr_back.sv
// Back end: frame tracking, CRC-8, checksum parse and result register.
module crc8fr_back (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [crc8fr_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [crc8fr_pkg::BYTE_W-1:0]       cfg_data,
  input  logic                                q_valid,
  input  crc8fr_pkg::item_t                   q_item,
  output logic                                q_pop,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [1:0]                          frame_status,
  output logic [crc8fr_pkg::BYTE_W-1:0]       command_byte,
  output logic [crc8fr_pkg::BYTE_W-1:0]       data_length,
  output logic [crc8fr_pkg::BYTE_W-1:0]       computed_crc,
  output logic [crc8fr_pkg::BYTE_W-1:0]       received_crc
);

  logic [crc8fr_pkg::BYTE_W-1:0] max_len;
  logic [crc8fr_pkg::BYTE_W-1:0] poly;

  crc8fr_pkg::frame_t  frame;
  crc8fr_pkg::frame_t  frame_next;
  logic                load;
  crc8fr_pkg::status_t res_status;
  crc8fr_pkg::status_t status_calc;
  logic [crc8fr_pkg::BYTE_W-1:0] cmd_calc;
  logic [crc8fr_pkg::BYTE_W-1:0] len_calc;
  logic [crc8fr_pkg::BYTE_W-1:0] crc_calc;
  logic [crc8fr_pkg::BYTE_W-1:0] rx_calc;
  logic [crc8fr_pkg::BYTE_W-1:0] dec_times_ten;

  function automatic logic [crc8fr_pkg::BYTE_W-1:0] crc8_step(
    input logic [crc8fr_pkg::BYTE_W-1:0] crc,
    input logic [crc8fr_pkg::BYTE_W-1:0] b,
    input logic [crc8fr_pkg::BYTE_W-1:0] p
  );
    logic [crc8fr_pkg::BYTE_W-1:0] v;
    v = crc ^ b;
    for (int k = 0; k < crc8fr_pkg::BYTE_W; k++) begin
      v = v[crc8fr_pkg::BYTE_W-1] ? ((v << 1) ^ p) : (v << 1);
    end
    return v;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      max_len <= crc8fr_pkg::MAX_LEN_RESET;
      poly    <= crc8fr_pkg::POLY_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        crc8fr_pkg::CFG_MAX_LEN: max_len <= cfg_data;
        crc8fr_pkg::CFG_POLY:    poly    <= cfg_data;
        default: ;
      endcase
    end
  end

  assign q_pop         = q_valid && (!out_valid || !out_stall);
  assign dec_times_ten = (frame.dec << 3) + (frame.dec << 1);

  always_comb begin
    frame_next = frame;
    load       = 1'b0;
    if (q_pop) begin
      if (!frame.in_frame && (q_item.kind == crc8fr_pkg::K_OPEN)) begin
        frame_next          = '0;
        frame_next.in_frame = 1'b1;
      end else if (frame.in_frame && (q_item.kind == crc8fr_pkg::K_CLOSE)) begin
        load       = (frame.count != '0);
        frame_next = '0;
      end else if (frame.in_frame && (frame.count < max_len)) begin
        if (frame.count == '0) begin
          frame_next.first_byte = q_item.data;
        end
        if (q_item.kind == crc8fr_pkg::K_COMMA) begin
          frame_next.crc_at_comma = frame.crc;
          frame_next.comma_pos    = frame.count;
          frame_next.comma_seen   = 1'b1;
          frame_next.dec          = '0;
          frame_next.dec_stopped  = 1'b0;
        end else if (frame.comma_seen && !frame.dec_stopped) begin
          if (q_item.kind == crc8fr_pkg::K_DIGIT) begin
            frame_next.dec = dec_times_ten + {4'b0, q_item.data[3:0]};
          end else begin
            frame_next.dec_stopped = 1'b1;
          end
        end
        frame_next.crc   = crc8_step(frame.crc, q_item.data, poly);
        frame_next.count = frame.count + 1'b1;
      end else begin
        frame_next = '0;
      end
    end
  end

  always_comb begin
    if (!frame.comma_seen) begin
      status_calc = crc8fr_pkg::ST_NO_COMMA;
      cmd_calc    = '0;
      len_calc    = '0;
      crc_calc    = '0;
      rx_calc     = '0;
    end else begin
      status_calc = (frame.crc_at_comma == frame.dec) ? crc8fr_pkg::ST_GOOD
                                                      : crc8fr_pkg::ST_MISMATCH;
      cmd_calc    = (frame.comma_pos != '0) ? frame.first_byte : '0;
      len_calc    = frame.comma_pos;
      crc_calc    = frame.crc_at_comma;
      rx_calc     = frame.dec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame     <= '0;
      out_valid <= 1'b0;
    end else begin
      frame <= frame_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_status   <= status_calc;
      command_byte <= cmd_calc;
      data_length  <= len_calc;
      computed_crc <= crc_calc;
      received_crc <= rx_calc;
    end
  end

  assign frame_status = res_status;

  a_idle_clear: assert property (@(posedge clk) disable iff (rst)
    !frame.in_frame |-> (frame.count == '0) && !frame.comma_seen)
    else $error("frame state not cleared outside a frame");

  a_comma_pos: assert property (@(posedge clk) disable iff (rst)
    frame.comma_seen |-> (frame.comma_pos < frame.count))
    else $error("comma position beyond byte count");

  a_dec_zero: assert property (@(posedge clk) disable iff (rst)
    !frame.comma_seen |-> (frame.dec == '0) && !frame.dec_stopped)
    else $error("checksum accumulated before any comma");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |-> !load)
    else $error("pending result overwritten");

endmodule
